FILE: src/lpc_pkg.sv
// Shared constants and types for the polynomial coefficient compressor.
package lpc_pkg;

  localparam int unsigned NUM_LANES = 8;
  localparam int unsigned COEFF_W   = 13;
  localparam int unsigned RES_W     = 12;
  localparam int unsigned NUM_W     = 17;
  localparam int unsigned RECIP_W   = 18;
  localparam int unsigned PROD_W    = NUM_W + RECIP_W;
  localparam int unsigned CVAL_W    = 5;
  localparam int unsigned PACK_W    = 40;
  localparam int unsigned CNT_W     = 3;

  // Modulus, its double for the reduction, and its half, used for the rounding offset.
  localparam logic signed [COEFF_W:0] KQ_S      = 14'sd3329;
  localparam logic signed [COEFF_W:0] KQ2_S     = 14'sd6658;
  localparam logic [NUM_W-1:0]        KQ_HALF   = 17'd1664;

  // ceil(2^29 / 3329); floor(n * RECIP >> 29) equals n / 3329 for every
  // numerator below 150000, which covers the largest one (108160).
  localparam logic [RECIP_W-1:0]      RECIP       = 18'd161271;
  localparam int unsigned             RECIP_SHIFT = 29;

  // Mode register codes.
  localparam logic [CNT_W-1:0] MODE_D4 = 3'd4;
  localparam logic [CNT_W-1:0] MODE_D5 = 3'd5;

  typedef logic [CVAL_W-1:0] cval_t;

  // Pipeline control that the top level hands to every lane.
  typedef struct packed {
    logic ld_s1;  // residue stage takes a new item
    logic ld_s2;  // divide stage takes the item from the residue stage
    logic d5_s1;  // item in the residue stage uses five bits per value
  } lane_ctl_t;

endpackage

FILE: src/lattice_poly_compress.sv
// Top level of the Kyber coefficient compressor for four or five bits per value.
// Items pass through a three-stage pipeline (residue register, reciprocal multiply
// register, packed output register) on their way to out_valid.
// Throughput: one item of eight coefficients per cycle while the output is not stalled.
// Reset (rst_n low, synchronous) empties the pipeline and sets the mode register to d = 4.
// Stalls on out_ready fill the bubbles ahead of the output before in_ready drops.
module lattice_poly_compress
  import lpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CNT_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COEFF_W-1:0] in_coeff_0,
  input  logic signed [COEFF_W-1:0] in_coeff_1,
  input  logic signed [COEFF_W-1:0] in_coeff_2,
  input  logic signed [COEFF_W-1:0] in_coeff_3,
  input  logic signed [COEFF_W-1:0] in_coeff_4,
  input  logic signed [COEFF_W-1:0] in_coeff_5,
  input  logic signed [COEFF_W-1:0] in_coeff_6,
  input  logic signed [COEFF_W-1:0] in_coeff_7,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PACK_W-1:0]         out_packed_out,
  output logic [CNT_W-1:0]          out_byte_count
);

  // The mode register. Only the code for five bits selects d = 5; every
  // other value behaves as d = 4.
  logic [CNT_W-1:0] mode_r;
  logic             mode_d5;

  // Valid bits and per-item mode for each pipeline stage.
  logic v1_r, v2_r, v3_r;
  logic d5_s1_r, d5_s2_r;
  logic ld1, ld2, ld3;

  logic signed [COEFF_W-1:0] coeff [NUM_LANES];
  cval_t                     cval  [NUM_LANES];
  lane_ctl_t                 ctl;

  logic [PACK_W-1:0] packed_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [PACK_W-1:0] packed_r;
  logic [CNT_W-1:0]  cnt_r;

  assign cfg_ready = 1'b1;
  assign mode_d5   = (mode_r == MODE_D5);

  // Each stage loads when it is empty or when its item moves on, so a
  // stalled output still lets items advance into empty slots behind it.
  assign ld3      = !v3_r || out_ready;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  assign ctl.ld_s1 = ld1;
  assign ctl.ld_s2 = ld2;
  assign ctl.d5_s1 = d5_s1_r;

  assign coeff[0] = in_coeff_0;
  assign coeff[1] = in_coeff_1;
  assign coeff[2] = in_coeff_2;
  assign coeff[3] = in_coeff_3;
  assign coeff[4] = in_coeff_4;
  assign coeff[5] = in_coeff_5;
  assign coeff[6] = in_coeff_6;
  assign coeff[7] = in_coeff_7;

  // Eight identical lanes, one per coefficient of the item.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lpc_lane u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .coeff (coeff[g]),
      .cval  (cval[g])
    );
  end

  // The merge stage combines the lane results into the packed bytes.
  lpc_pack u_pack (
    .cval       (cval),
    .d5         (d5_s2_r),
    .packed_val (packed_nxt),
    .byte_cnt   (cnt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_D4;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (ld1) begin
        v1_r <= in_valid;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (ld3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (ld1) begin
      d5_s1_r <= mode_d5;
    end
    if (ld2) begin
      d5_s2_r <= d5_s1_r;
    end
    if (ld3) begin
      packed_r <= packed_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign out_valid      = v3_r;
  assign out_packed_out = packed_r;
  assign out_byte_count = cnt_r;

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted item did not enter the residue stage");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!v1_r || !v2_r || !v3_r) |-> in_ready)
    else $error("input stalled while the pipeline has a free slot");

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count == MODE_D4 || out_byte_count == MODE_D5))
    else $error("byte count is neither four nor five");

  a_d4_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_count == MODE_D4) |-> (out_packed_out[PACK_W-1:32] == '0))
    else $error("upper byte not zero in four-bit mode");
`endif

endmodule

FILE: src/lpc_lane.sv
// One coefficient lane: reduction to [0, q) and compression by reciprocal multiply.
module lpc_lane
  import lpc_pkg::*;
(
  input  logic                      clk,
  input  lane_ctl_t                 ctl,
  input  logic signed [COEFF_W-1:0] coeff,
  output cval_t                     cval
);

  logic signed [COEFF_W:0] c_ext;
  logic signed [COEFF_W:0] c_red;
  logic [RES_W-1:0]        x_r;
  logic [RES_W-1:0]        x_nxt;
  logic [NUM_W-1:0]        num;
  logic [PROD_W-1:0]       prod;
  cval_t                   cval_r;
  cval_t                   cval_nxt;

  // Bring the coefficient to its standard representative.
  always_comb begin
    c_ext = {coeff[COEFF_W-1], coeff};
    if (c_ext < -KQ_S) begin
      c_red = c_ext + KQ2_S;
    end else if (c_ext < 0) begin
      c_red = c_ext + KQ_S;
    end else if (c_ext >= KQ_S) begin
      c_red = c_ext - KQ_S;
    end else begin
      c_red = c_ext;
    end
    x_nxt = c_red[RES_W-1:0];
  end

  // Rounded quotient (x * 2^d + q/2) / q via the reciprocal.
  always_comb begin
    if (ctl.d5_s1) begin
      num = {x_r, 5'b0} + KQ_HALF;
    end else begin
      num = {1'b0, x_r, 4'b0} + KQ_HALF;
    end
    prod     = PROD_W'(num) * PROD_W'(RECIP);
    cval_nxt = prod[RECIP_SHIFT +: CVAL_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_s1) begin
      x_r <= x_nxt;
    end
    if (ctl.ld_s2) begin
      cval_r <= cval_nxt;
    end
  end

  assign cval = cval_r;

endmodule

FILE: src/lpc_pack.sv
// Merge stage: packs the eight lane results into little-endian bytes.
module lpc_pack
  import lpc_pkg::*;
(
  input  cval_t             cval [NUM_LANES],
  input  logic              d5,
  output logic [PACK_W-1:0] packed_val,
  output logic [CNT_W-1:0]  byte_cnt
);

  always_comb begin
    packed_val = '0;
    for (int j = 0; j < NUM_LANES; j++) begin
      if (d5) begin
        packed_val[CVAL_W*j +: CVAL_W] = cval[j];
      end else begin
        packed_val[(CVAL_W-1)*j +: (CVAL_W-1)] = cval[j][CVAL_W-2:0];
      end
    end
    byte_cnt = d5 ? MODE_D5 : MODE_D4;
  end

endmodule
